/* rtl/crd_pkg.sv */
// ----------------------------------------------------------------------------
// crd_pkg: shared constants for the compression rate detector
// Field widths, register indexes, reset values, arithmetic constants and controller state codes.
// ----------------------------------------------------------------------------
package crd_pkg;

  // Field widths
  localparam int SampleW   = 16;
  localparam int TimeW     = 32;
  localparam int ThreshW   = 15;
  localparam int StepW     = 16;
  localparam int LimitW    = 7;
  localparam int RateW     = 16;
  localparam int TotalW    = 16;
  localparam int FallW     = 8;
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 16;

  // Dividend is 60000 * limit, at most 60000 * 127
  localparam int DividendW = 23;
  localparam int DivCountW = 5;

  // Stream payload widths, padded to whole bytes
  localparam int InDataW  = 48;
  localparam int OutDataW = 40;

  // Register indexes
  localparam logic [CfgIndexW-1:0] REG_DETECT  = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_RELEASE = 2'd1;
  localparam logic [CfgIndexW-1:0] REG_MAXSTEP = 2'd2;
  localparam logic [CfgIndexW-1:0] REG_LIMIT   = 2'd3;

  // Register reset values
  localparam logic [ThreshW-1:0] DETECT_RST  = 15'd1000;
  localparam logic [ThreshW-1:0] RELEASE_RST = 15'd800;
  localparam logic [StepW-1:0]   MAXSTEP_RST = 16'd300;
  localparam logic [LimitW-1:0]  LIMIT_RST   = 7'd10;

  // Arithmetic constants
  localparam logic [RateW-1:0]  MS_PER_MINUTE = 16'd60000;
  localparam logic [RateW-1:0]  RATE_MAX      = 16'hFFFF;
  localparam logic [TotalW-1:0] TOTAL_MAX     = 16'hFFFF;
  localparam logic [FallW-1:0]  FALL_MAX      = 8'hFF;

  // Controller states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

endpackage

/* rtl/crd_div.sv */
// ----------------------------------------------------------------------------
// crd_div: bit-serial restoring divider for the rate computation
// Produces one quotient bit per cycle and saturates the result to 16 bits.
// ----------------------------------------------------------------------------
module crd_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [crd_pkg::DividendW-1:0]      dividend,
  input  logic [crd_pkg::TimeW-1:0]          divisor,
  output logic                               done,
  output logic [crd_pkg::RateW-1:0]          quotient
);

  logic                            busy;
  logic [crd_pkg::DivCountW-1:0]   count;
  logic [crd_pkg::DividendW-1:0]   shreg;
  logic [crd_pkg::TimeW-1:0]       rem;
  logic [crd_pkg::TimeW-1:0]       dvs;
  logic [crd_pkg::TimeW:0]         trial;
  logic [crd_pkg::TimeW:0]         diff;
  logic                            qbit;

  // Trial subtract of the divisor from the partial remainder
  always_comb begin
    trial = {rem, shreg[crd_pkg::DividendW-1]};
    diff  = trial - {1'b0, dvs};
    qbit  = ~diff[crd_pkg::TimeW];
  end

  // Control: step count and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= crd_pkg::DivCountW'(crd_pkg::DividendW);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == crd_pkg::DivCountW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out the top while quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dvs   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[crd_pkg::DividendW-2:0], qbit};
      rem   <= qbit ? diff[crd_pkg::TimeW-1:0] : trial[crd_pkg::TimeW-1:0];
    end
  end

  // Saturate; a zero divisor yields an all-ones quotient and saturates too
  assign quotient = (|shreg[crd_pkg::DividendW-1:crd_pkg::RateW]) ? crd_pkg::RATE_MAX
                                                                  : shreg[crd_pkg::RateW-1:0];

endmodule

/* rtl/compression_rate_detector.sv */
// ----------------------------------------------------------------------------
// compression_rate_detector: chest-compression rate from accelerometer samples
// Tracks falling steps, marks compressions and times a set number of them.
// ----------------------------------------------------------------------------
// Flow: a sample that computes no rate goes from acceptance to ST_DONE, then
// into the output register once the slot is free; one that computes a rate
// first waits in ST_DIV through the 23 divider steps (one quotient bit per cycle).
// One sample at a time: no new sample is accepted until the result is loaded.
// Reset: synchronous rst clears all tracking state and loads register defaults.
module compression_rate_detector (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write port
  input  logic                             cfg_we,
  input  logic [crd_pkg::CfgIndexW-1:0]    cfg_index,
  input  logic [crd_pkg::CfgDataW-1:0]     cfg_data,
  // Input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [crd_pkg::InDataW-1:0]      s_tdata,  // accel_sample[15:0], timestamp_ms[47:16]
  // Result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [crd_pkg::OutDataW-1:0]     m_tdata   // compression_seen[0], rate_updated[1],
                                                     // rate_per_minute[17:2],
                                                     // total_compressions[33:18], zero pad
);

  // Configuration registers
  logic [crd_pkg::ThreshW-1:0] detect_threshold;
  logic [crd_pkg::ThreshW-1:0] release_threshold;
  logic [crd_pkg::StepW-1:0]   max_fall_step;
  logic [crd_pkg::LimitW-1:0]  compressions_per_measure;

  // Tracking state
  logic [1:0]                     state;
  logic signed [crd_pkg::SampleW-1:0] previous_sample;
  logic                           in_period;
  logic [crd_pkg::FallW-1:0]      fall_count;
  logic [crd_pkg::LimitW-1:0]     cycle_count;
  logic [crd_pkg::TimeW-1:0]      cycle_start_time;
  logic [crd_pkg::RateW-1:0]      last_rate;
  logic [crd_pkg::TotalW-1:0]     compression_total;
  logic                           res_seen;
  logic                           res_updated;

  // Per-sample decision terms
  logic                           accept;
  logic signed [crd_pkg::SampleW-1:0] now;
  logic [crd_pkg::TimeW-1:0]      ts;
  logic [crd_pkg::SampleW:0]      now_ext;
  logic [crd_pkg::SampleW:0]      mag;
  logic [crd_pkg::SampleW:0]      drop;
  logic                           falling;
  logic                           rising;
  logic                           fall_ok;
  logic                           release_hit;
  logic [crd_pkg::FallW-1:0]      fall_count_next;
  logic                           in_period_mid;
  logic                           seen;
  logic [crd_pkg::LimitW-1:0]     cycle_count_next;
  logic [crd_pkg::LimitW-1:0]     limit;
  logic                           updated;
  logic                           first_of_measure;
  logic [crd_pkg::TimeW-1:0]      start_eff;
  logic [crd_pkg::TimeW-1:0]      elapsed;
  logic [crd_pkg::DividendW-1:0]  dividend;
  logic                           div_done;
  logic [crd_pkg::RateW-1:0]      div_quotient;
  logic                           out_free;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == crd_pkg::ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Classify the sample against the previous one
  always_comb begin
    now     = s_tdata[crd_pkg::SampleW-1:0];
    ts      = s_tdata[crd_pkg::SampleW +: crd_pkg::TimeW];
    now_ext = {now[crd_pkg::SampleW-1], now};
    mag     = now[crd_pkg::SampleW-1] ? ((crd_pkg::SampleW+1)'(0) - now_ext) : now_ext;
    drop    = {previous_sample[crd_pkg::SampleW-1], previous_sample} - now_ext;
    falling = now < previous_sample;
    rising  = now > previous_sample;
    fall_ok = falling
           && (mag > {2'b00, detect_threshold})
           && (drop[crd_pkg::StepW-1:0] < max_fall_step);
    release_hit = !fall_ok && rising && (mag < {2'b00, release_threshold});

    fall_count_next = fall_count;
    in_period_mid   = in_period;
    if (fall_ok) begin
      if (fall_count != crd_pkg::FALL_MAX) fall_count_next = fall_count + 1'b1;
    end else if (release_hit) begin
      fall_count_next = '0;
      in_period_mid   = 1'b0;
    end

    seen             = rising && (fall_count_next != '0) && !in_period_mid;
    cycle_count_next = seen ? cycle_count + 1'b1 : cycle_count;
    limit            = (compressions_per_measure == '0) ? crd_pkg::LimitW'(1)
                                                        : compressions_per_measure;
    updated          = seen && (cycle_count_next >= limit);
    first_of_measure = seen && (cycle_count_next == crd_pkg::LimitW'(1));
    start_eff        = first_of_measure ? ts : cycle_start_time;
    elapsed          = ts - start_eff;
    dividend         = crd_pkg::DividendW'(crd_pkg::MS_PER_MINUTE)
                     * crd_pkg::DividendW'(limit);
  end

  // Rate division
  crd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && updated),
    .dividend (dividend),
    .divisor  (elapsed),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      detect_threshold         <= crd_pkg::DETECT_RST;
      release_threshold        <= crd_pkg::RELEASE_RST;
      max_fall_step            <= crd_pkg::MAXSTEP_RST;
      compressions_per_measure <= crd_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        crd_pkg::REG_DETECT:  detect_threshold  <= cfg_data[crd_pkg::ThreshW-1:0];
        crd_pkg::REG_RELEASE: release_threshold <= cfg_data[crd_pkg::ThreshW-1:0];
        crd_pkg::REG_MAXSTEP: max_fall_step     <= cfg_data[crd_pkg::StepW-1:0];
        crd_pkg::REG_LIMIT:   compressions_per_measure <= cfg_data[crd_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= crd_pkg::ST_IDLE;
      previous_sample   <= '0;
      in_period         <= 1'b0;
      fall_count        <= '0;
      cycle_count       <= '0;
      cycle_start_time  <= '0;
      last_rate         <= '0;
      compression_total <= '0;
      res_seen          <= 1'b0;
      res_updated       <= 1'b0;
    end else begin
      case (state)
        crd_pkg::ST_IDLE: begin
          if (accept) begin
            previous_sample <= now;
            fall_count      <= fall_count_next;
            in_period       <= seen ? 1'b1 : in_period_mid;
            cycle_count     <= updated ? '0 : cycle_count_next;
            if (first_of_measure) cycle_start_time <= ts;
            if (seen && compression_total != crd_pkg::TOTAL_MAX)
              compression_total <= compression_total + 1'b1;
            res_seen    <= seen;
            res_updated <= updated;
            state       <= updated ? crd_pkg::ST_DIV : crd_pkg::ST_DONE;
          end
        end
        crd_pkg::ST_DIV: begin
          // Hold until the divider finishes, then latch the rate
          if (div_done) begin
            last_rate <= div_quotient;
            state     <= crd_pkg::ST_DONE;
          end
        end
        crd_pkg::ST_DONE: begin
          if (out_free) state <= crd_pkg::ST_IDLE;
        end
        default: state <= crd_pkg::ST_IDLE;
      endcase
    end
  end

  // Output register: load when the result is ready and the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == crd_pkg::ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == crd_pkg::ST_DONE && out_free) begin
      m_tdata <= {6'b0, compression_total, last_rate, res_updated, res_seen};
    end
  end

endmodule

/* rtl/crd_checker.sv */
// ----------------------------------------------------------------------------
// crd_checker: port-level checks for the compression rate detector
// Watches the stream handshakes and result flags over time.
// ----------------------------------------------------------------------------
module crd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [crd_pkg::OutDataW-1:0]  m_tdata
);

  // A stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // One sample in flight: no acceptance right after a transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a sample is in progress");

  // A new rate only comes with a compression
  a_rate_needs_seen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[1] && !m_tdata[0]))
    else $error("rate_updated without compression_seen");

  // Reset leaves no result pending
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind compression_rate_detector crd_checker u_crd_checker (.*);
